@@ rtl/kmds_pkg.sv @@
`default_nettype none

package kmds_pkg;

    localparam int NUM_POS    = 64;
    localparam int POS_W      = 6;
    localparam int STAMP_W    = 32;
    localparam int DEB_W      = 10;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 64;
    localparam int IN_DATA_W  = 96;
    localparam int OUT_DATA_W = 16;

    localparam logic [DEB_W-1:0]   DEBOUNCE_RST = 10'd20;
    localparam logic [POS_W-1:0]   ALPHA_RST    = 6'd0;
    localparam logic [POS_W-1:0]   SHIFT_RST    = 6'd1;
    localparam logic [POS_W-1:0]   LAST_POS     = 6'd63;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEBOUNCE_MS  = 4'd0,
        CFG_PRESENT_MASK = 4'd1,
        CFG_ALPHA_KEY    = 4'd2,
        CFG_SHIFT_KEY    = 4'd3
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_HOLD
    } scan_state_t;

    // Per-key stored state, as it sits at the head of the ring.
    typedef struct packed {
        logic               raw;
        logic               rep;
        logic [STAMP_W-1:0] stamp;
    } key_state_t;

    // What the evaluator needs to know about the key under the head.
    typedef struct packed {
        logic               present;
        logic               reading;
        logic [POS_W-1:0]   pos;
        logic [STAMP_W-1:0] now;
        logic [DEB_W-1:0]   debounce;
        logic [POS_W-1:0]   alpha_idx;
        logic [POS_W-1:0]   shift_idx;
    } key_probe_t;

    typedef struct packed {
        logic hit;
        logic toggle_alpha;
        logic toggle_shift;
    } key_verdict_t;

endpackage

`default_nettype wire

@@ rtl/keypad_matrix_debounce_scanner.sv @@
`default_nettype none

// Channel  | Direction | Payload (low bit first)
// s_       | in        | tdata: now_ms[31:0], pressed_bits[63:0]
// m_       | out       | tdata: key_valid, key_index[5:0], alpha_on, shift_on, 7 zero bits
// cfg_     | in        | cfg_index selects the register, cfg_data carries the value
//
// A scan accepts its input, walks all 64 key positions, one key position per cycle,
// through the rotating key-state ring and the input bit shifters, and then posts the
// result. A stalled result register holds the scan in its final state until m_tready
// frees it; a new scan is accepted only while idle.
// Reset is synchronous, active low, and clears all key state and mode flags.

module keypad_matrix_debounce_scanner #(
    parameter int ROWS = 8,
    parameter int COLS = 8
) (
    input  wire                                 aclk,
    input  wire                                 aresetn,
    input  wire                                 s_tvalid,
    output logic                                s_tready,
    input  wire  [kmds_pkg::IN_DATA_W-1:0]      s_tdata,   // now_ms[31:0], pressed_bits[95:32]
    output logic                                m_tvalid,
    input  wire                                 m_tready,
    output logic [kmds_pkg::OUT_DATA_W-1:0]     m_tdata,   // key_valid[0], key_index[6:1],
                                                           // alpha_on[7], shift_on[8], zero
    input  wire                                 cfg_valid,
    output logic                                cfg_ready,
    input  wire  [kmds_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire  [kmds_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import kmds_pkg::*;

    localparam logic [POS_W:0] KEY_COUNT = (POS_W+1)'(ROWS * COLS);

    scan_state_t        state_reg, state_next;
    logic [POS_W-1:0]   cnt_reg, cnt_next;
    logic [STAMP_W-1:0] now_reg, now_next;
    logic [NUM_POS-1:0] bits_sr_reg, bits_sr_next;
    logic [NUM_POS-1:0] mask_sr_reg, mask_sr_next;
    logic               found_valid_reg, found_valid_next;
    logic [POS_W-1:0]   found_idx_reg, found_idx_next;
    logic               alpha_mode_reg, alpha_mode_next;
    logic               shift_mode_reg, shift_mode_next;
    logic               m_valid_reg, m_valid_next;
    logic [OUT_DATA_W-1:0] m_data_reg, m_data_next;

    logic [DEB_W-1:0]   debounce_reg;
    logic [NUM_POS-1:0] present_mask_reg;
    logic [POS_W-1:0]   alpha_key_reg;
    logic [POS_W-1:0]   shift_key_reg;

    key_probe_t   probe;
    key_state_t   head;
    key_state_t   upd;
    key_verdict_t verdict;
    logic         walking;
    logic         out_free;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;
    assign walking   = (state_reg == ST_WALK);
    assign out_free  = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_reg     <= DEBOUNCE_RST;
            present_mask_reg <= '1;
            alpha_key_reg    <= ALPHA_RST;
            shift_key_reg    <= SHIFT_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_DEBOUNCE_MS:  debounce_reg     <= cfg_data[DEB_W-1:0];
                CFG_PRESENT_MASK: present_mask_reg <= cfg_data[NUM_POS-1:0];
                CFG_ALPHA_KEY:    alpha_key_reg    <= cfg_data[POS_W-1:0];
                CFG_SHIFT_KEY:    shift_key_reg    <= cfg_data[POS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        probe.present   = mask_sr_reg[0] && ({1'b0, cnt_reg} < KEY_COUNT);
        probe.reading   = bits_sr_reg[0];
        probe.pos       = cnt_reg;
        probe.now       = now_reg;
        probe.debounce  = debounce_reg;
        probe.alpha_idx = alpha_key_reg;
        probe.shift_idx = shift_key_reg;
    end

    kmds_key_ring u_ring (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .shift_en  (walking),
        .new_entry (upd),
        .head      (head)
    );

    kmds_key_eval u_eval (
        .probe   (probe),
        .cur     (head),
        .upd     (upd),
        .verdict (verdict)
    );

    always_comb begin
        state_next       = state_reg;
        cnt_next         = cnt_reg;
        now_next         = now_reg;
        bits_sr_next     = bits_sr_reg;
        mask_sr_next     = mask_sr_reg;
        found_valid_next = found_valid_reg;
        found_idx_next   = found_idx_reg;
        alpha_mode_next  = alpha_mode_reg;
        shift_mode_next  = shift_mode_reg;
        m_valid_next     = m_tready ? 1'b0 : m_valid_reg;
        m_data_next      = m_data_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    now_next         = s_tdata[STAMP_W-1:0];
                    bits_sr_next     = s_tdata[STAMP_W +: NUM_POS];
                    mask_sr_next     = present_mask_reg;
                    cnt_next         = '0;
                    found_valid_next = 1'b0;
                    found_idx_next   = '0;
                    state_next       = ST_WALK;
                end
            end
            ST_WALK: begin
                bits_sr_next = bits_sr_reg >> 1;
                mask_sr_next = mask_sr_reg >> 1;
                cnt_next     = cnt_reg + 1'b1;
                if (verdict.toggle_alpha) begin
                    alpha_mode_next = !alpha_mode_reg;
                end
                if (verdict.toggle_shift) begin
                    shift_mode_next = !shift_mode_reg;
                end
                // Later keys overwrite earlier ones.
                if (verdict.hit) begin
                    found_valid_next = 1'b1;
                    found_idx_next   = cnt_reg;
                end
                if (cnt_reg == LAST_POS) begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (out_free) begin
                    shift_mode_next = found_valid_reg ? 1'b0 : shift_mode_reg;
                    m_valid_next    = 1'b1;
                    m_data_next     = {7'b0, shift_mode_next, alpha_mode_reg,
                                       found_idx_reg, found_valid_reg};
                    state_next      = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            cnt_reg         <= '0;
            found_valid_reg <= 1'b0;
            found_idx_reg   <= '0;
            alpha_mode_reg  <= 1'b0;
            shift_mode_reg  <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            cnt_reg         <= cnt_next;
            found_valid_reg <= found_valid_next;
            found_idx_reg   <= found_idx_next;
            alpha_mode_reg  <= alpha_mode_next;
            shift_mode_reg  <= shift_mode_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        now_reg     <= now_next;
        bits_sr_reg <= bits_sr_next;
        mask_sr_reg <= mask_sr_next;
        m_data_reg  <= m_data_next;
    end

    a_accept_starts_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (walking && !s_tready))
        else $error("accepted scan did not start the walk");

    a_idle_counter_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (walking && cnt_reg == LAST_POS) |=> (state_reg == ST_HOLD && cnt_reg == '0))
        else $error("walk did not end after the last key position");

    a_key_clears_shift: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[0] && m_tdata[8]))
        else $error("reported key left shift mode set");

    a_no_key_zero_index: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tdata[0]) |-> (m_tdata[6:1] == '0))
        else $error("key index nonzero without a reported key");

endmodule

`default_nettype wire

@@ rtl/kmds_key_ring.sv @@
`default_nettype none

module kmds_key_ring (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 shift_en,
    input  wire kmds_pkg::key_state_t new_entry,
    output kmds_pkg::key_state_t head
);
    import kmds_pkg::*;

    logic [NUM_POS-1:0] raw_reg;
    logic [NUM_POS-1:0] rep_reg;
    logic [STAMP_W-1:0] stamp_reg [NUM_POS];

    assign head.raw   = raw_reg[0];
    assign head.rep   = rep_reg[0];
    assign head.stamp = stamp_reg[0];

    // Rotate by one key per cycle while shift_en is high; a full walk of NUM_POS shifts realigns the ring.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            raw_reg <= '0;
            rep_reg <= '0;
            for (int i = 0; i < NUM_POS; i++) begin
                stamp_reg[i] <= '0;
            end
        end else if (shift_en) begin
            raw_reg <= {new_entry.raw, raw_reg[NUM_POS-1:1]};
            rep_reg <= {new_entry.rep, rep_reg[NUM_POS-1:1]};
            for (int i = 0; i < NUM_POS - 1; i++) begin
                stamp_reg[i] <= stamp_reg[i+1];
            end
            stamp_reg[NUM_POS-1] <= new_entry.stamp;
        end
    end

endmodule

`default_nettype wire

@@ rtl/kmds_key_eval.sv @@
`default_nettype none

module kmds_key_eval (
    input  wire kmds_pkg::key_probe_t probe,
    input  wire kmds_pkg::key_state_t cur,
    output kmds_pkg::key_state_t   upd,
    output kmds_pkg::key_verdict_t verdict
);
    import kmds_pkg::*;

    logic [STAMP_W-1:0] stamp_new;
    logic [STAMP_W-1:0] elapsed;
    logic               settled;
    logic               update;
    logic               press;
    logic               is_alpha;
    logic               is_shift;

    always_comb begin
        stamp_new = (probe.present && (probe.reading != cur.raw)) ? probe.now : cur.stamp;
        elapsed   = probe.now - stamp_new;
        settled   = elapsed >= {{(STAMP_W-DEB_W){1'b0}}, probe.debounce};
        update    = probe.present && settled && (probe.reading != cur.rep);
        press     = update && probe.reading;
        // Alpha takes precedence when both toggles name the same key.
        is_alpha  = press && (probe.pos == probe.alpha_idx);
        is_shift  = press && !is_alpha && (probe.pos == probe.shift_idx);

        upd.stamp = stamp_new;
        upd.rep   = update ? probe.reading : cur.rep;
        // Hold the raw level of a toggle key on its new press.
        upd.raw   = (probe.present && !is_alpha && !is_shift) ? probe.reading : cur.raw;

        verdict.hit          = press && !is_alpha && !is_shift;
        verdict.toggle_alpha = is_alpha;
        verdict.toggle_shift = is_shift;
    end

endmodule

`default_nettype wire

@@ tb/keypad_matrix_debounce_scanner_tb.sv @@
`default_nettype none

module keypad_matrix_debounce_scanner_tb;

    import kmds_pkg::*;

    localparam int SCAN_KEYS   = 64;
    localparam int HOLD_CYCLES = 400;
    localparam int IDLE_LIMIT  = 5000;

    typedef struct packed {
        logic             valid;
        logic [POS_W-1:0] idx;
        logic             alpha;
        logic             shift;
    } key_event_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_DEBOUNCE_MS;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // Mirror of the block's registers and per-key state
    logic [DEB_W-1:0]   debounce_q   = DEBOUNCE_RST;
    logic [63:0]        mask_q       = '1;
    logic [POS_W-1:0]   alpha_key_q  = ALPHA_RST;
    logic [POS_W-1:0]   shift_key_q  = SHIFT_RST;
    logic [63:0]        raw_q        = '0;
    logic [63:0]        rep_q        = '0;
    logic [STAMP_W-1:0] stamp_q [SCAN_KEYS];
    logic               alpha_mode_q = 1'b0;
    logic               shift_mode_q = 1'b0;

    key_event_t pending_events[$];
    int         mismatch_count = 0;
    int         idle_cycles    = 0;
    int         stall_left     = 0;
    int         hold_req       = 0;
    int         hold_ack       = 0;
    bit         src_steady     = 1'b1;
    bit         sink_steady    = 1'b1;

    keypad_matrix_debounce_scanner i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 aclk = ~aclk;

    initial begin
        for (int k = 0; k < SCAN_KEYS; k++) begin
            stamp_q[k] = '0;
        end
    end

    function automatic key_event_t predict_scan(input logic [31:0] now_ms,
                                                input logic [63:0] bits);
        key_event_t       ev;
        logic             reading;
        logic [31:0]      age;
        ev = '0;
        for (int k = 0; k < SCAN_KEYS; k++) begin
            if (!mask_q[k]) continue;
            reading = bits[k];
            if (reading != raw_q[k]) stamp_q[k] = now_ms;
            age = now_ms - stamp_q[k];
            if (age >= {22'd0, debounce_q} && reading != rep_q[k]) begin
                rep_q[k] = reading;
                if (reading) begin
                    // toggle keys leave their raw level untouched
                    if (k[POS_W-1:0] == alpha_key_q) begin
                        alpha_mode_q = ~alpha_mode_q;
                        continue;
                    end
                    if (k[POS_W-1:0] == shift_key_q) begin
                        shift_mode_q = ~shift_mode_q;
                        continue;
                    end
                    ev.valid = 1'b1;
                    ev.idx   = k[POS_W-1:0];
                end
            end
            raw_q[k] = reading;
        end
        if (ev.valid) shift_mode_q = 1'b0;
        ev.alpha = alpha_mode_q;
        ev.shift = shift_mode_q;
        return ev;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (src_steady || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(20, 150);
    endfunction

    task automatic send_scan(input logic [31:0] now_ms, input logic [63:0] bits);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {bits, now_ms};
        do @(posedge aclk); while (!s_tready);
        pending_events.push_back(predict_scan(now_ms, bits));
    endtask

    // Drop valid and wait until every scan result is back
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_events.size() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [63:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_DEBOUNCE_MS:  debounce_q  = val[DEB_W-1:0];
            CFG_PRESENT_MASK: mask_q      = val;
            CFG_ALPHA_KEY:    alpha_key_q = val[POS_W-1:0];
            CFG_SHIFT_KEY:    shift_key_q = val[POS_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [9:0] deb, input logic [63:0] mask,
                              input logic [5:0] alpha, input logic [5:0] shift);
        drain();
        write_reg(CFG_DEBOUNCE_MS, {54'd0, deb});
        write_reg(CFG_PRESENT_MASK, mask);
        write_reg(CFG_ALPHA_KEY, {58'd0, alpha});
        write_reg(CFG_SHIFT_KEY, {58'd0, shift});
        cfg_valid <= 1'b0;
    endtask

    // Reset settings: press, hold, toggle keys, highest index, time wrap
    task automatic test_directed_defaults();
        send_scan(32'd0,  64'd0);
        send_scan(32'd5,  64'd1 << 5);
        send_scan(32'd25, 64'd1 << 5);
        send_scan(32'd30, 64'd1);
        send_scan(32'd50, 64'd1);
        send_scan(32'd70, (64'd1 << 1) | (64'd1 << 63) | (64'd1 << 40));
        send_scan(32'd90, (64'd1 << 1) | (64'd1 << 63) | (64'd1 << 40));
        send_scan(32'hFFFF_FFF0, '1);
        send_scan(32'h0000_0004, '1);
        send_scan(32'hFFFF_FFFF, 64'd0);
    endtask

    // Zero debounce, alpha and shift on one index
    task automatic test_zero_debounce();
        set_config(10'd0, '1, 6'd63, 6'd63);
        send_scan(32'd1000, 64'd1 << 63);
        send_scan(32'd1001, 64'd0);
        send_scan(32'd1002, 64'd1 << 63);
        send_scan(32'd1003, (64'd1 << 62) | (64'd1 << 2));
        send_scan(32'd1004, '1);
    endtask

    // Longest debounce with the alpha key absent, then an empty matrix
    task automatic test_long_debounce_and_mask();
        set_config(10'd1023, ~(64'd1 << 9), 6'd9, 6'd10);
        send_scan(32'd0,    (64'd1 << 9) | (64'd1 << 10) | (64'd1 << 3));
        send_scan(32'd1022, (64'd1 << 9) | (64'd1 << 10) | (64'd1 << 3));
        send_scan(32'd1023, (64'd1 << 9) | (64'd1 << 10) | (64'd1 << 3));
        send_scan(32'd2100, 64'd1 << 9);
        set_config(10'd20, 64'd0, 6'd0, 6'd1);
        send_scan(32'd50,  '1);
        send_scan(32'd100, '1);
    endtask

    task automatic run_random_scans(input int count, input int deb_lo, input int deb_hi,
                                    input bit sparse_mask);
        logic [63:0] mask;
        logic [63:0] held;
        logic [63:0] bits;
        logic [31:0] clock_ms;
        logic [5:0]  alpha;
        logic [5:0]  shift;
        int          pos;
        if (sparse_mask) mask = {$urandom, $urandom};
        else mask = ~({$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom});
        alpha = 6'($urandom_range(0, 63));
        shift = 6'($urandom_range(0, 63));
        set_config(10'($urandom_range(deb_lo, deb_hi)), mask, alpha, shift);
        held     = '0;
        clock_ms = $urandom;
        for (int i = 0; i < count; i++) begin
            // a held key changes now and then, toggle keys get a fair share
            if ($urandom_range(0, 99) < 20) begin
                case ($urandom_range(0, 7))
                    0:       pos = int'(alpha);
                    1:       pos = int'(shift);
                    default: pos = $urandom_range(0, 63);
                endcase
                held ^= 64'd1 << pos;
            end else if ($urandom_range(0, 99) < 4) begin
                held = '0;
            end
            if ($urandom_range(0, 15) == 0) clock_ms += $urandom_range(0, 3 * deb_hi + 5);
            else clock_ms += 1;
            bits = held;
            if ($urandom_range(0, 9) == 0) bits ^= 64'd1 << $urandom_range(0, 63);
            if ($urandom_range(0, 24) == 0) begin
                bits     = {$urandom, $urandom};
                clock_ms = $urandom;
            end
            send_scan(clock_ms, bits);
        end
    endtask

    task automatic test_random_phases();
        src_steady = 1'b1; sink_steady = 1'b1;
        run_random_scans(60, 0, 4, 1'b0);
        src_steady = 1'b0; sink_steady = 1'b0;
        run_random_scans(100, 0, 4, 1'b0);
        src_steady = 1'b0; sink_steady = 1'b1;
        run_random_scans(80, 5, 30, 1'b0);
        src_steady = 1'b1; sink_steady = 1'b0;
        run_random_scans(70, 0, 1023, 1'b1);
        src_steady = 1'b0; sink_steady = 1'b0;
        run_random_scans(80, 0, 8, 1'b0);
    endtask

    // Receiver holds off while scans keep coming
    task automatic test_backpressure();
        logic [31:0] clock_ms;
        drain();
        src_steady = 1'b1;
        hold_req <= hold_req + 1;
        clock_ms = $urandom;
        for (int i = 0; i < 8; i++) begin
            clock_ms += 1;
            send_scan(clock_ms, (i < 5) ? (64'd1 << 20) : {$urandom, $urandom});
        end
        src_steady = 1'b0;
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed_defaults();
        test_zero_debounce();
        test_long_debounce_and_mask();
        test_backpressure();
        test_random_phases();
        drain();
        repeat (100) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready   <= 1'b0;
            stall_left <= 0;
        end else if (hold_req != hold_ack) begin
            hold_ack   <= hold_req;
            stall_left <= HOLD_CYCLES;
            m_tready   <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else if (!sink_steady && $urandom_range(0, 99) < 15) begin
            stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(0, 3);
            m_tready   <= 1'b0;
        end else begin
            m_tready   <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        key_event_t want;
        key_event_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tdata[0], m_tdata[6:1], m_tdata[7], m_tdata[8]};
            if (pending_events.size() == 0) begin
                $display("%0t unexpected result transaction %h", $time, m_tdata);
                mismatch_count++;
            end else begin
                want = pending_events.pop_front();
                if (got != want) begin
                    $display("%0t expected v=%0d i=%0d a=%0d s=%0d actual v=%0d i=%0d a=%0d s=%0d",
                             $time, want.valid, want.idx, want.alpha, want.shift,
                             got.valid, got.idx, got.alpha, got.shift);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
                $display("%0t no transaction for %0d cycles", $time, IDLE_LIMIT);
                $display("Mismatches found");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

endmodule

`default_nettype wire

@@ filelist.f @@
rtl/kmds_pkg.sv
rtl/kmds_key_ring.sv
rtl/kmds_key_eval.sv
rtl/keypad_matrix_debounce_scanner.sv
tb/keypad_matrix_debounce_scanner_tb.sv
